### rtl/wleb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wleb_pkg: shared types and constants of the LEB128 immediate encoder
// Operation codes, opcode bytes, step unit modes and the control and status
// groups that pass between the sequencer and the shared step unit.
// ----------------------------------------------------------------------------
package wleb_pkg;

    localparam int OP_W   = 4;
    localparam int VAL_W  = 64;
    localparam int BYTE_W = 8;

    // Operation codes of an input beat.
    localparam logic [OP_W-1:0] OP_LOCAL_GET  = 4'd0;
    localparam logic [OP_W-1:0] OP_LOCAL_SET  = 4'd1;
    localparam logic [OP_W-1:0] OP_LOCAL_TEE  = 4'd2;
    localparam logic [OP_W-1:0] OP_GLOBAL_GET = 4'd3;
    localparam logic [OP_W-1:0] OP_GLOBAL_SET = 4'd4;
    localparam logic [OP_W-1:0] OP_I32_CONST  = 4'd5;
    localparam logic [OP_W-1:0] OP_I64_CONST  = 4'd6;
    localparam logic [OP_W-1:0] OP_F64_CONST  = 4'd7;
    localparam logic [OP_W-1:0] OP_MEMARG     = 4'd8;
    localparam logic [OP_W-1:0] OP_ULEB32     = 4'd9;
    localparam logic [OP_W-1:0] OP_SLEB32     = 4'd10;
    localparam logic [OP_W-1:0] OP_SLEB64     = 4'd11;

    // Instruction opcode bytes.
    localparam logic [BYTE_W-1:0] OPC_LOCAL_GET = 8'h20;
    localparam logic [BYTE_W-1:0] OPC_I32_CONST = 8'h41;
    localparam logic [BYTE_W-1:0] OPC_I64_CONST = 8'h42;
    localparam logic [BYTE_W-1:0] OPC_F64_CONST = 8'h44;

    localparam logic [BYTE_W-1:0] CONT_BIT   = 8'h80;
    localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;

    // Step unit modes.
    localparam logic [1:0] MODE_ULEB = 2'd0;
    localparam logic [1:0] MODE_SLEB = 2'd1;
    localparam logic [1:0] MODE_RAW  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [1:0] mode;
    } t_step_ctl;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              more;
    } t_step_sts;

endpackage

### rtl/wleb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wleb_if: valid/ready channels of the LEB128 immediate encoder
// The input channel carries an operation and its 64-bit operand; the output
// channel carries one encoded byte and a last-byte flag per beat.
// ----------------------------------------------------------------------------
interface wleb_in_if;
    logic                valid;
    logic                ready;
    logic [3:0]          operation;
    logic signed [63:0]  value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface wleb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

### rtl/wleb_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wleb_step_unit: shared shift and compare unit
// Holds the working operand and, per step, forms the next byte and shifts the
// operand by seven bits (LEB128) or eight bits (raw little-endian bytes).
// ----------------------------------------------------------------------------
module wleb_step_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wleb_pkg::t_step_ctl  i_ctl,
    input  logic [63:0]          i_load_val,
    output wleb_pkg::t_step_sts  o_sts
);
    import wleb_pkg::*;

    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] n_val;
    logic [1:0]       r_mode;
    logic [2:0]       r_cnt;
    logic [VAL_W-1:0] w_ush;
    logic [VAL_W-1:0] w_ssh;
    logic [6:0]       w_low;

    assign w_low = r_val[6:0];
    assign w_ush = r_val >> 7;
    assign w_ssh = {{7{r_val[VAL_W-1]}}, r_val[VAL_W-1:7]};

    always_comb begin
        o_sts = '0;
        n_val = r_val;
        case (r_mode)
            MODE_ULEB: begin
                o_sts.more     = (w_ush != '0);
                o_sts.out_byte = {o_sts.more, w_low};
                n_val          = w_ush;
            end
            MODE_SLEB: begin
                // Stop once the rest is pure sign and bit six already shows it.
                o_sts.more     = !(((w_ssh == '0) && !w_low[6]) ||
                                   ((w_ssh == '1) && w_low[6]));
                o_sts.out_byte = {o_sts.more, w_low};
                n_val          = w_ssh;
            end
            MODE_RAW: begin
                o_sts.more     = (r_cnt != 3'd7);
                o_sts.out_byte = r_val[BYTE_W-1:0];
                n_val          = r_val >> BYTE_W;
            end
            default: begin
                o_sts.more     = 1'b0;
                o_sts.out_byte = ZERO_BYTE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= i_load_val;
        end else if (i_ctl.step) begin
            r_val <= n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ULEB;
            r_cnt  <= '0;
        end else if (i_ctl.load) begin
            r_mode <= i_ctl.mode;
            r_cnt  <= '0;
        end else if (i_ctl.step) begin
            r_cnt  <= r_cnt + 3'd1;
        end
    end

endmodule

### rtl/wasm_immediate_leb128_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wasm_immediate_leb128_encoder_unit: WebAssembly immediate byte encoder
// Turns one operation and a 64-bit operand into a run of encoded bytes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel i_in takes one beat per item: an operation code and a
// 64-bit operand. The output channel o_out gives one encoded byte per beat,
// with last_byte set on the final byte of the item.
// Instruction forms emit their opcode byte first, then the immediate as
// unsigned or signed LEB128, or as eight little-endian bytes for f64.const.
// A memarg ends with a zero offset byte. Undefined operation codes are
// accepted and produce no output beats.
// Timing: the block takes one item at a time. After the input beat, one byte
// enters the output register per cycle while o_out does not stall; an item
// is at most eleven bytes (an opcode and a ten-byte signed 64-bit encoding).
// The accepted item first moves the sequencer to its opcode or body state,
// from which the first byte enters the output register. The shared step
// unit forms each LEB128 or raw byte combinationally from its operand.
// A stall on o_out holds the current byte and freezes the sequencer; input
// ready stays low until the last byte has been loaded into the output
// register. Synchronous reset returns the sequencer to idle and empties the
// output register.
// ----------------------------------------------------------------------------
module wasm_immediate_leb128_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wleb_in_if.sink     i_in,
    wleb_out_if.source  o_out
);
    import wleb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_OPC  = 2'd1;
    localparam logic [1:0] ST_BODY = 2'd2;
    localparam logic [1:0] ST_TAIL = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [BYTE_W-1:0] r_opc;
    logic [BYTE_W-1:0] n_opc;
    logic              r_tail;
    logic              n_tail;

    // Output register.
    logic              r_ovalid;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_olast;

    t_step_ctl         w_ctl;
    t_step_sts         w_sts;
    logic [VAL_W-1:0]  w_load_val;
    logic              w_accept;
    logic              w_can_push;
    logic              w_push;
    logic [BYTE_W-1:0] w_byte;
    logic              w_last;
    logic [OP_W-1:0]   w_op;

    assign w_op       = i_in.operation;
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_can_push = !r_ovalid || o_out.ready;

    wleb_step_unit u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_load_val (w_load_val),
        .o_sts      (w_sts)
    );

    // Decode of an incoming operation: operand form, opcode and next state.
    always_comb begin
        w_load_val = i_in.value;
        w_ctl      = '0;
        n_state    = r_state;
        n_opc      = r_opc;
        n_tail     = r_tail;
        w_push     = 1'b0;
        w_byte     = ZERO_BYTE;
        w_last     = 1'b0;

        if (w_op inside {OP_LOCAL_GET, OP_LOCAL_SET, OP_LOCAL_TEE, OP_GLOBAL_GET,
                         OP_GLOBAL_SET, OP_MEMARG, OP_ULEB32}) begin
            w_load_val = {32'd0, i_in.value[31:0]};
            w_ctl.mode = MODE_ULEB;
        end else if (w_op inside {OP_I32_CONST, OP_SLEB32}) begin
            w_load_val = {{32{i_in.value[31]}}, i_in.value[31:0]};
            w_ctl.mode = MODE_SLEB;
        end else if (w_op == OP_F64_CONST) begin
            w_ctl.mode = MODE_RAW;
        end else begin
            w_ctl.mode = MODE_SLEB;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_ctl.load = 1'b1;
                    n_tail     = (w_op == OP_MEMARG);
                    if (w_op inside {[OP_LOCAL_GET:OP_GLOBAL_SET]}) begin
                        n_opc   = OPC_LOCAL_GET + {4'd0, w_op};
                        n_state = ST_OPC;
                    end else if (w_op == OP_I32_CONST) begin
                        n_opc   = OPC_I32_CONST;
                        n_state = ST_OPC;
                    end else if (w_op == OP_I64_CONST) begin
                        n_opc   = OPC_I64_CONST;
                        n_state = ST_OPC;
                    end else if (w_op == OP_F64_CONST) begin
                        n_opc   = OPC_F64_CONST;
                        n_state = ST_OPC;
                    end else if (w_op inside {[OP_MEMARG:OP_SLEB64]}) begin
                        n_state = ST_BODY;
                    end else begin
                        // Undefined operation: dropped without output.
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OPC: begin
                if (w_can_push) begin
                    w_push  = 1'b1;
                    w_byte  = r_opc;
                    n_state = ST_BODY;
                end
            end
            ST_BODY: begin
                if (w_can_push) begin
                    w_push     = 1'b1;
                    w_ctl.step = 1'b1;
                    w_byte     = w_sts.out_byte;
                    if (!w_sts.more) begin
                        w_last  = !r_tail;
                        n_state = r_tail ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (w_can_push) begin
                    w_push  = 1'b1;
                    w_byte  = ZERO_BYTE;
                    w_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tail   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tail  <= n_tail;
            if (w_push) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_opc <= n_opc;
        if (w_push) begin
            r_obyte <= w_byte;
            r_olast <= w_last;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.out_byte  = r_obyte;
    assign o_out.last_byte = r_olast;

endmodule
